// ----- rtl/dnvcb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the day/night vertex color blend.
// No dependencies; every other file in rtl/ imports this package.
package dnvcb_pkg;

    // Pipeline stages, in order from input to output register
    localparam int NUM_STG   = 7;
    localparam int STG_UNIT  = 0;
    localparam int STG_PROD  = 1;
    localparam int STG_MIX   = 2;
    localparam int STG_CHAN  = 3;
    localparam int STG_SUM   = 4;
    localparam int STG_BOOST = 5;
    localparam int STG_OUT   = 6;

    // Day/night ratio register
    localparam int             RATIO_W   = 10;
    localparam logic [RATIO_W-1:0] RATIO_RST = 10'd1000;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 10'd1000;

    // Q16 constants
    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [16:0] ART_Q16    = 17'd68157;
    localparam logic [16:0] SUN_RG_OFS = 17'd2621;
    localparam logic [16:0] SUN_B_OFS  = 17'd5112;

    // Sun tint at full day, loaded by reset
    localparam logic signed [16:0] SUN_RG_RST = 17'sd62915;
    localparam logic [16:0]        SUN_B_RST  = 17'd69337;
    localparam logic signed [17:0] SUN_RG_MIN = -18'sd2621;

    // Red/green tint: (65536*r + 500) / 1000 = 65*r + (134*r + 125) / 250
    localparam logic [7:0]  RG_NUM_MUL = 8'd134;
    localparam logic [6:0]  RG_NUM_OFS = 7'd125;
    localparam logic [6:0]  RG_INT_MUL = 7'd65;
    localparam logic [16:0] RG_RECIP   = 17'd67109;   // ceil(2^24 / 250)
    localparam int          RG_SHIFT   = 24;

    // Blue tint: (6422528*r + 50000) / 100000 = 64*r + (1408*r + 3125) / 6250
    localparam logic [10:0] B_NUM_MUL = 11'd1408;
    localparam logic [11:0] B_NUM_OFS = 12'd3125;
    localparam logic [19:0] B_RECIP   = 20'd687195;   // ceil(2^32 / 6250)
    localparam int          B_SHIFT   = 32;

    // Dark-blue boost table, indexed by the clamped average divided by 8
    localparam int BOOST_N = 32;
    localparam logic [2:0] BOOST_TAB [BOOST_N] = '{
        3'd1, 3'd4, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4, 3'd3,
        3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };

    // Channel sum at which the boost index reaches k: ceil(k * 8 * 3 * 65536 / 255).
    // Past the last nonzero entry the index only selects zeros.
    localparam int BOOST_THR_N = 10;
    localparam logic [15:0] BOOST_THR [BOOST_THR_N] = '{
        16'((1  * 1572864 + 254) / 255),
        16'((2  * 1572864 + 254) / 255),
        16'((3  * 1572864 + 254) / 255),
        16'((4  * 1572864 + 254) / 255),
        16'((5  * 1572864 + 254) / 255),
        16'((6  * 1572864 + 254) / 255),
        16'((7  * 1572864 + 254) / 255),
        16'((8  * 1572864 + 254) / 255),
        16'((9  * 1572864 + 254) / 255),
        16'((10 * 1572864 + 254) / 255)
    };

    // Payload types
    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_day_weight;
    } t_vtx_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_vtx_out;

    // Sunlight tint factors, Q16
    typedef struct packed {
        logic signed [16:0] rg;
        logic [16:0]        b;
    } t_sun;

    // Lit channels before the boost, Q16
    typedef struct packed {
        logic signed [18:0] red;
        logic signed [18:0] green;
        logic [17:0]        blue;
    } t_chan;

    // Per-stage load enables
    typedef struct packed {
        logic [NUM_STG-1:0] en;
    } t_pipe_ctl;

    // Byte to Q16: (x*65536 + 127) / 255 = 257*x + (x >= 128)
    function automatic logic [16:0] unit_q16(input logic [7:0] x);
        return {1'b0, x, 8'b0} + {9'b0, x} + {16'b0, x[7]};
    endfunction

endpackage

// ----- rtl/dnvcb_sun.sv -----
`timescale 1ns / 1ps
// Day/night ratio register and the sunlight tint factors derived from it.
// Depends on dnvcb_pkg.
module dnvcb_sun
    import dnvcb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [RATIO_W-1:0] i_cfg_data,
    output t_sun               o_sun
);

    logic [RATIO_W-1:0] r_ratio;
    t_sun               r_sun;
    t_sun               n_sun;
    logic [RATIO_W-1:0] sat;
    logic [17:0]        rg_num;
    logic [34:0]        rg_prod;
    logic [9:0]         rg_q;
    logic [16:0]        rg_sum;
    logic [20:0]        b_num;
    logic [40:0]        b_prod;
    logic [7:0]         b_q;

    // Hold the written ratio
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RST;
        end else if (i_cfg_we) begin
            r_ratio <= i_cfg_data;
        end
    end

    // Saturate, then divide by the constants through reciprocal multiplies
    always_comb begin
        sat     = (r_ratio > RATIO_MAX) ? RATIO_MAX : r_ratio;
        rg_num  = 18'(sat) * 18'(RG_NUM_MUL) + 18'(RG_NUM_OFS);
        rg_prod = 35'(rg_num) * 35'(RG_RECIP);
        rg_q    = rg_prod[RG_SHIFT +: 10];
        rg_sum  = 17'(sat) * 17'(RG_INT_MUL) + 17'(rg_q);
        b_num   = 21'(sat) * 21'(B_NUM_MUL) + 21'(B_NUM_OFS);
        b_prod  = 41'(b_num) * 41'(B_RECIP);
        b_q     = b_prod[B_SHIFT +: 8];
        n_sun.rg = 17'($signed({1'b0, rg_sum}) - $signed({1'b0, SUN_RG_OFS}));
        n_sun.b  = {1'b0, sat, 6'b0} + 17'(b_q) + SUN_B_OFS;
    end

    // Register the tint factors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sun.rg <= SUN_RG_RST;
            r_sun.b  <= SUN_B_RST;
        end else begin
            r_sun <= n_sun;
        end
    end

    assign o_sun = r_sun;

    a_rg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sun.rg >= SUN_RG_MIN) && (r_sun.rg <= SUN_RG_RST))
        else $error("red/green tint out of range");

    a_b_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sun.b >= SUN_B_OFS) && (r_sun.b <= SUN_B_RST))
        else $error("blue tint out of range");

    a_b_above_rg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $signed({1'b0, r_sun.b}) > r_sun.rg)
        else $error("blue tint not above red/green tint");

endmodule

// ----- rtl/dnvcb_ctrl.sv -----
`timescale 1ns / 1ps
// Valid tracking and per-stage load enables for the blend pipeline.
// Depends on dnvcb_pkg.
module dnvcb_ctrl
    import dnvcb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  logic      i_ready,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG-1:0] en;

    // A stage loads when it is empty or its item moves on; bubbles fill under stall
    always_comb begin
        en[NUM_STG-1] = !r_vld[NUM_STG-1] || i_ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    // Advance valid bits with the data
    always_comb begin
        n_vld[0] = en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NUM_STG; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready  = en[0];
    assign o_valid  = r_vld[NUM_STG-1];
    assign o_ctl.en = en;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    a_en_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((en >> 1) & ~en) == '0)
        else $error("stage loads while the stage before it holds");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transaction lost at first stage");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule

// ----- rtl/dnvcb_light.sv -----
`timescale 1ns / 1ps
// Front half of the blend pipeline: unit conversion, light mix, lit channels.
// Depends on dnvcb_pkg; tint factors come from dnvcb_sun.
module dnvcb_light
    import dnvcb_pkg::*;
(
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_vtx_in   i_data,
    input  t_sun      i_sun,
    output t_chan     o_chan
);

    // Unit stage
    logic [16:0] r_a;
    logic [16:0] r_n;
    logic [16:0] r_c0 [3];

    // Product stage
    logic signed [33:0] r_p_rg;
    logic [32:0]        r_p_b;
    logic [32:0]        r_p_art;
    logic [16:0]        r_c1 [3];

    // Mix stage
    logic signed [17:0] r_mix_rg;
    logic [16:0]        r_mix_b;
    logic [16:0]        r_c2 [3];

    // Channel stage
    t_chan r_chan;

    logic signed [34:0] p_rg;
    logic signed [34:0] s_rg;
    logic [33:0]        s_b;
    logic signed [35:0] p_red;
    logic signed [35:0] p_green;
    logic [34:0]        p_blue;

    // Convert bytes to Q16 and form the artificial-light share
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_UNIT]) begin
            r_a     <= unit_q16(i_data.in_day_weight);
            r_n     <= ONE_Q16 - unit_q16(i_data.in_day_weight);
            r_c0[0] <= unit_q16(i_data.in_red);
            r_c0[1] <= unit_q16(i_data.in_green);
            r_c0[2] <= unit_q16(i_data.in_blue);
        end
    end

    // Weigh sun tint and artificial light
    assign p_rg = $signed({1'b0, r_a}) * i_sun.rg;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_PROD]) begin
            r_p_rg  <= p_rg[33:0];
            r_p_b   <= 33'(r_a) * 33'(i_sun.b);
            r_p_art <= 33'(r_n) * 33'(ART_Q16);
            r_c1    <= r_c0;
        end
    end

    // Sum the shares and round to Q16
    assign s_rg = $signed({r_p_rg[33], r_p_rg}) + $signed({2'b0, r_p_art})
                  + 35'sd32768;
    assign s_b  = 34'(r_p_b) + 34'(r_p_art) + 34'd32768;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_MIX]) begin
            r_mix_rg <= s_rg[33:16];
            r_mix_b  <= s_b[32:16];
            r_c2     <= r_c1;
        end
    end

    // Color times mix times two, rounded
    assign p_red   = $signed({1'b0, r_c2[0]}) * r_mix_rg + 36'sd16384;
    assign p_green = $signed({1'b0, r_c2[1]}) * r_mix_rg + 36'sd16384;
    assign p_blue  = 35'(r_c2[2]) * 35'(r_mix_b) + 35'd16384;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_CHAN]) begin
            r_chan.red   <= p_red[33:15];
            r_chan.green <= p_green[33:15];
            r_chan.blue  <= p_blue[32:15];
        end
    end

    assign o_chan = r_chan;

endmodule

// ----- rtl/dnvcb_boost.sv -----
`timescale 1ns / 1ps
// Back half of the blend pipeline: channel average, dark-blue boost, byte clamp.
// Depends on dnvcb_pkg; lit channels come from dnvcb_light.
module dnvcb_boost
    import dnvcb_pkg::*;
(
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_chan     i_chan,
    output t_vtx_out  o_data
);

    logic signed [19:0]     r_sum;
    t_chan                  r_chan4;
    logic signed [18:0]     r_red5;
    logic signed [18:0]     r_green5;
    logic [17:0]            r_blue5;
    t_vtx_out               r_out;
    logic [BOOST_THR_N-1:0] pass;
    logic [4:0]             boost_idx;
    logic [2:0]             boost;

    // Q16 channel to byte: scale by 255, truncate, clamp
    function automatic logic [7:0] to_byte(input logic signed [18:0] v);
        logic [26:0] s;
        logic [7:0]  b;
        s = 27'(v[17:0]) * 27'd255;
        if (v <= 19'sd0) begin
            b = 8'd0;
        end else if (s[26:16] > 11'd255) begin
            b = 8'd255;
        end else begin
            b = s[23:16];
        end
        return b;
    endfunction

    // Sum the three channels
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_SUM]) begin
            r_sum   <= 20'(i_chan.red) + 20'(i_chan.green)
                       + $signed({2'b0, i_chan.blue});
            r_chan4 <= i_chan;
        end
    end

    // Find the boost index by comparing the sum against the step points
    always_comb begin
        for (int j = 0; j < BOOST_THR_N; j++) begin
            pass[j] = !r_sum[19] && (r_sum[18:0] >= {3'b0, BOOST_THR[j]});
        end
        boost_idx = 5'($countones(pass));
        boost     = BOOST_TAB[boost_idx];
    end

    // Add the boost to blue in units of 1/255
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_BOOST]) begin
            r_red5   <= r_chan4.red;
            r_green5 <= r_chan4.green;
            r_blue5  <= r_chan4.blue + {7'b0, boost, 8'b0} + {15'b0, boost};
        end
    end

    // Clamp into the output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_OUT]) begin
            r_out.out_red   <= to_byte(r_red5);
            r_out.out_green <= to_byte(r_green5);
            r_out.out_blue  <= to_byte($signed({1'b0, r_blue5}));
        end
    end

    assign o_data = r_out;

endmodule

// ----- rtl/day_night_vertex_color_blend.sv -----
`timescale 1ns / 1ps
// Top level of the day/night vertex color blend.
// Depends on dnvcb_pkg, dnvcb_sun, dnvcb_ctrl, dnvcb_light and dnvcb_boost.
//
//   Channel  Handshake            Payload      Direction
//   input    i_valid / o_ready    i_data       vertex color and day weight in
//   output   o_valid / i_ready    o_data       lit color out
//   config   i_cfg_we             i_cfg_data   day/night ratio, write only
//
// One transaction per cycle sustained while the output does not stall, through the
// seven-register pipeline (unit, product, mix, channel, sum, boost, out).
// Synchronous active-low reset empties the pipeline and sets the ratio to full day.
// A stall at the output fills bubbles first; input ready drops only when all seven
// stages hold a transaction. A ratio write passes the ratio, then the tint register.
module day_night_vertex_color_blend
    import dnvcb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_vtx_in            i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output t_vtx_out           o_data,
    input  logic               i_cfg_we,
    input  logic [RATIO_W-1:0] i_cfg_data
);

    t_sun      sun;
    t_pipe_ctl ctl;
    t_chan     chan;

    // Ratio register and tint
    dnvcb_sun u_sun (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_sun      (sun)
    );

    // Flow control
    dnvcb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_ctl   (ctl)
    );

    // Light mix and lit channels
    dnvcb_light u_light (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_data (i_data),
        .i_sun  (sun),
        .o_chan (chan)
    );

    // Boost and clamp
    dnvcb_boost u_boost (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_chan (chan),
        .o_data (o_data)
    );

endmodule
